// ===== design/cpr_pkg.sv =====
package cpr_pkg;

   // operation broadcast to every frame cell in a cycle
   typedef enum logic [2:0] {
      OP_NOP,
      OP_HIT,
      OP_FILL,
      OP_STEP,
      OP_NORM
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        clear;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SWEEP
   } state_type;

   localparam int FAULT_W = 32;
   localparam int CFG_W   = 4;

endpackage

// ===== design/clock_page_replacement_top.sv =====
// channel  | ports                         | beat content (low bits first)
// ---------+-------------------------------+------------------------------------------
// request  | req_tvalid/tready/tdata/tlast | tdata: page; tlast: last_in_trace
// response | rsp_tvalid/tready/tdata/tuser | tdata: frame_slot, evicted_page,
//          | /tlast                        | fault_count; tuser: hit, replaced;
//          |                               | tlast: trace_done
// csr      | csr_we/csr_wdata              | frames_in_use, written when csr_we is high
//
// one request at a time: a hit or a fill is accepted, then looked up in the filled active cells
// a miss with all frames full walks the clock hand one cell per cycle, clearing the
// reference bits it skips; a hand past the active count first restarts at frame 0
// reset (synchronous, active high) clears reference bits, fill count, hand and fault count
// a stalled response holds its register; the next request is still taken meanwhile
module clock_page_replacement_top #(
   parameter  int FRAMES    = 8,
   parameter  int PAGE_BITS = 16,
   localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int CNT_W     = $clog2(FRAMES + 1),
   localparam int REQ_W     = ((PAGE_BITS + 7) / 8) * 8,
   localparam int RSP_W     = ((SLOT_W + PAGE_BITS + 32 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // page
   input  logic             req_tlast,   // last_in_trace
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // frame_slot, evicted_page, fault_count
   output logic [1:0]       rsp_tuser,   // hit, replaced
   output logic             rsp_tlast,   // trace_done
   // configuration
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata    // frames_in_use
);
   import cpr_pkg::*;

   // control state
   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     csr_ff;
   logic [CNT_W-1:0]     filled_ff, filled_in;
   logic [FAULT_W-1:0]   faults_ff, faults_in;

   // beat being worked on
   logic [PAGE_BITS-1:0] key_ff;
   logic                 last_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 hit_ff, repl_ff, done_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [PAGE_BITS-1:0] evict_ff;
   logic [FAULT_W-1:0]   count_ff;

   // values loaded into the response register
   logic                 out_hit, out_repl;
   logic [SLOT_W-1:0]    out_slot;
   logic [PAGE_BITS-1:0] out_evict;
   logic [FAULT_W-1:0]   out_count;

   logic [CNT_W-1:0]     act_n;
   logic [FAULT_W-1:0]   fault_inc;
   logic                 accept, out_free, emit, has_room;
   cell_ctl_type         ctl;

   logic                 hit, victim_found, tok_stray;
   logic [SLOT_W-1:0]    hit_slot, victim_slot;
   logic [PAGE_BITS-1:0] evict_page;

   cpr_chain #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .SLOT_W    (SLOT_W),
      .CNT_W     (CNT_W)
   ) u_chain (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .key          (key_ff),
      .act_n        (act_n),
      .filled       (filled_ff),
      .hit          (hit),
      .hit_slot     (hit_slot),
      .victim_found (victim_found),
      .victim_slot  (victim_slot),
      .evict_page   (evict_page),
      .tok_stray    (tok_stray)
   );

   // active frame count: zero acts as one, anything above the build size is clamped
   always_comb begin
      if (csr_ff == '0) begin
         act_n = CNT_W'(1);
      end else if (32'(csr_ff) > FRAMES) begin
         act_n = CNT_W'(FRAMES);
      end else begin
         act_n = CNT_W'(csr_ff);
      end
   end

   assign has_room   = filled_ff < act_n;
   assign fault_inc  = (faults_ff == '1) ? faults_ff : faults_ff + FAULT_W'(1);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (emit) begin
               state_in = ST_IDLE;
            end else if (!hit && !has_room) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // cell commands and response values
   always_comb begin
      ctl.op    = OP_NOP;
      ctl.clear = 1'b0;
      emit      = 1'b0;
      out_hit   = 1'b0;
      out_repl  = 1'b0;
      out_slot  = '0;
      out_evict = '0;
      out_count = faults_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOK: begin
            if (out_free && hit) begin
               ctl.op   = OP_HIT;
               emit     = 1'b1;
               out_hit  = 1'b1;
               out_slot = hit_slot;
            end else if (out_free && !hit && has_room) begin
               ctl.op   = OP_FILL;
               emit     = 1'b1;
               out_slot = SLOT_W'(filled_ff);
            end
         end
         ST_SWEEP: begin
            if (tok_stray) begin
               // hand beyond a shrunk frame count restarts at frame 0
               ctl.op = OP_NORM;
            end else if (!victim_found) begin
               // second chance: clear the bit and move the hand on
               ctl.op = OP_STEP;
            end else if (out_free) begin
               ctl.op    = OP_STEP;
               emit      = 1'b1;
               out_repl  = 1'b1;
               out_slot  = victim_slot;
               out_evict = evict_page;
               out_count = fault_inc;
            end
         end
         default: begin
         end
      endcase
      ctl.clear = emit & last_ff;
   end

   always_comb begin
      filled_in = filled_ff;
      faults_in = faults_ff;
      if (ctl.op == OP_FILL) filled_in = filled_ff + CNT_W'(1);
      if (emit && out_repl)  faults_in = fault_inc;
      // end of trace wipes the run state after its result
      if (ctl.clear) begin
         filled_in = '0;
         faults_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CFG_W'(8);
         filled_ff    <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         faults_ff <= faults_in;
         if (csr_we) csr_ff <= csr_wdata;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= req_tdata[PAGE_BITS-1:0];
         last_ff <= req_tlast;
      end
      if (emit) begin
         hit_ff   <= out_hit;
         repl_ff  <= out_repl;
         slot_ff  <= out_slot;
         evict_ff <= out_evict;
         count_ff <= out_count;
         done_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({count_ff, evict_ff, slot_ff});
   assign rsp_tuser  = {repl_ff, hit_ff};
   assign rsp_tlast  = done_ff;

endmodule

// ===== design/cpr_cell.sv =====
module cpr_cell #(
   parameter int IDX       = 0,
   parameter int PAGE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpr_pkg::cell_ctl_type  ctl,
   input  logic [PAGE_BITS-1:0]   key,
   input  logic                   is_search,
   input  logic                   is_fill,
   input  logic                   tok_from_prev,
   input  logic                   seen_in,
   output logic                   seen_out,
   output logic                   hit_here,
   output logic                   tok_to_next,
   output logic                   tok_here,
   output logic                   victim,
   output logic [PAGE_BITS-1:0]   evict
);
   import cpr_pkg::*;

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 ref_ff, ref_in;
   logic                 tok_ff, tok_in;
   logic                 match;

   // compare and token outputs
   always_comb begin
      match       = is_search & (page_ff == key);
      seen_out    = seen_in | match;
      hit_here    = match & ~seen_in;
      tok_to_next = (ctl.op == OP_STEP) & tok_ff;
      tok_here    = tok_ff;
      victim      = tok_ff & ~ref_ff;
      evict       = victim ? page_ff : '0;
   end

   always_comb begin
      page_in = page_ff;
      ref_in  = ref_ff;
      tok_in  = tok_ff;
      case (ctl.op)
         OP_HIT: begin
            if (hit_here) ref_in = 1'b1;
         end
         OP_FILL: begin
            if (is_fill) begin
               page_in = key;
               ref_in  = 1'b1;
            end
         end
         OP_STEP: begin
            tok_in = tok_from_prev;
            if (tok_ff) begin
               if (ref_ff) begin
                  ref_in = 1'b0;
               end else begin
                  page_in = key;
                  ref_in  = 1'b1;
               end
            end
         end
         OP_NORM: begin
            tok_in = 1'(IDX == 0);
         end
         default: begin
         end
      endcase
      if (ctl.clear) begin
         ref_in = 1'b0;
         tok_in = 1'(IDX == 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= 1'b0;
         tok_ff <= 1'(IDX == 0);
      end else begin
         ref_ff <= ref_in;
         tok_ff <= tok_in;
      end
   end

   // page store has no reset, only filled frames are ever read
   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

// ===== design/cpr_chain.sv =====
module cpr_chain #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16,
   parameter int SLOT_W    = 3,
   parameter int CNT_W     = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpr_pkg::cell_ctl_type  ctl,
   input  logic [PAGE_BITS-1:0]   key,
   input  logic [CNT_W-1:0]       act_n,
   input  logic [CNT_W-1:0]       filled,
   output logic                   hit,
   output logic [SLOT_W-1:0]      hit_slot,
   output logic                   victim_found,
   output logic [SLOT_W-1:0]      victim_slot,
   output logic [PAGE_BITS-1:0]   evict_page,
   output logic                   tok_stray
);
   import cpr_pkg::*;

   logic [FRAMES-1:0]    is_active, is_last, is_search, is_fill;
   logic [FRAMES-1:0]    tok_from_prev, tok_to_next, tok_here;
   logic [FRAMES-1:0]    hit_vec, victim_vec;
   logic [FRAMES:0]      seen;
   logic [PAGE_BITS-1:0] evict_vec [FRAMES];

   assign seen[0] = 1'b0;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         is_active[i] = CNT_W'(i) < act_n;
         is_last[i]   = CNT_W'(i + 1) == act_n;
         is_search[i] = is_active[i] & (CNT_W'(i) < filled);
         is_fill[i]   = CNT_W'(i) == filled;
      end
      // the hand wraps from the last active frame back to frame 0
      tok_from_prev[0] = |(tok_to_next & is_last);
      for (int i = 1; i < FRAMES; i++) begin
         tok_from_prev[i] = tok_to_next[i-1] & ~is_last[i-1];
      end
   end

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      cpr_cell #(
         .IDX       (g),
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .key           (key),
         .is_search     (is_search[g]),
         .is_fill       (is_fill[g]),
         .tok_from_prev (tok_from_prev[g]),
         .seen_in       (seen[g]),
         .seen_out      (seen[g+1]),
         .hit_here      (hit_vec[g]),
         .tok_to_next   (tok_to_next[g]),
         .tok_here      (tok_here[g]),
         .victim        (victim_vec[g]),
         .evict         (evict_vec[g])
      );
   end

   always_comb begin
      hit          = seen[FRAMES];
      victim_found = |victim_vec;
      tok_stray    = |(tok_here & ~is_active);
      hit_slot     = '0;
      victim_slot  = '0;
      evict_page   = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (hit_vec[i])    hit_slot    = hit_slot | SLOT_W'(i);
         if (victim_vec[i]) victim_slot = victim_slot | SLOT_W'(i);
         evict_page = evict_page | evict_vec[i];
      end
   end

endmodule

// ===== test/clock_page_checker.sv =====
module clock_page_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [15:0]              req_tdata,   // page
   input  logic                     req_tlast,   // last_in_trace
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [55:0]              rsp_tdata,   // frame_slot, evicted_page, fault_count
   input  logic [1:0]               rsp_tuser,   // hit, replaced
   input  logic                     rsp_tlast,   // trace_done
   input  logic                     csr_we,
   input  logic [cpr_pkg::CFG_W-1:0] csr_wdata,  // frames_in_use
   output int                       fail_count,
   output int                       outstanding
);
   import cpr_pkg::*;

   localparam int FRAMES = 8;

   typedef struct packed {
      logic               hit;
      logic               replaced;
      logic [2:0]         slot;
      logic [15:0]        evicted;
      logic [FAULT_W-1:0] faults;
      logic               done;
   } page_outcome_type;

   // shadow of the frame table and clock hand
   logic [15:0]        slot_page [FRAMES];
   logic               slot_ref  [FRAMES];
   int unsigned        filled;
   int unsigned        hand;
   logic [FAULT_W-1:0] faults;
   logic [CFG_W-1:0]   frames_cfg;

   page_outcome_type expected_q [$];

   function void clear_trace();
      for (int k = 0; k < FRAMES; k++) begin
         slot_page[k] = '0;
         slot_ref[k]  = 1'b0;
      end
      filled = 0;
      hand   = 0;
      faults = '0;
   endfunction

   task resolve_reference(input logic [15:0] pg, input logic lst, output page_outcome_type res);
      int unsigned active;
      int unsigned limit;
      active = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
      limit  = (filled < active) ? filled : active;
      res      = '0;
      res.done = lst;
      for (int unsigned i = 0; i < limit; i++) begin
         if (!res.hit && slot_page[i] == pg) begin
            res.hit  = 1'b1;
            res.slot = 3'(i);
         end
      end
      if (res.hit) begin
         slot_ref[res.slot] = 1'b1;
      end else if (filled < active) begin
         res.slot          = 3'(filled);
         slot_page[filled] = pg;
         slot_ref[filled]  = 1'b1;
         filled++;
      end else begin
         // hand past a shrunk frame count restarts at frame 0
         if (hand >= active) hand = 0;
         while (slot_ref[hand]) begin
            slot_ref[hand] = 1'b0;
            hand = (hand + 1 >= active) ? 0 : hand + 1;
         end
         res.slot        = 3'(hand);
         res.evicted     = slot_page[hand];
         slot_page[hand] = pg;
         slot_ref[hand]  = 1'b1;
         hand = (hand + 1 >= active) ? 0 : hand + 1;
         if (faults != '1) faults++;
         res.replaced = 1'b1;
      end
      res.faults = faults;
      if (lst) clear_trace();
   endtask

   task automatic note_field(input string label, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      page_outcome_type want;
      page_outcome_type got;
      if (reset) begin
         clear_trace();
         frames_cfg = 4'd8;
         expected_q.delete();
      end else begin
         if (csr_we) frames_cfg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.hit      = rsp_tuser[0];
            got.replaced = rsp_tuser[1];
            got.slot     = rsp_tdata[2:0];
            got.evicted  = rsp_tdata[18:3];
            got.faults   = rsp_tdata[50:19];
            got.done     = rsp_tlast;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual %0h",
                        $time, got);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               note_field("hit", want.hit, got.hit);
               note_field("replaced", want.replaced, got.replaced);
               note_field("frame_slot", want.slot, got.slot);
               note_field("evicted_page", want.evicted, got.evicted);
               note_field("fault_count", want.faults, got.faults);
               note_field("trace_done", want.done, got.done);
            end
         end
         if (req_tvalid && req_tready) begin
            resolve_reference(req_tdata, req_tlast, want);
            expected_q.push_back(want);
         end
      end
      outstanding = expected_q.size();
   end

endmodule

// ===== test/tb_clock_page_replacement_top.sv =====
module tb_clock_page_replacement_top;

   // free-running clock, period 10
   logic clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // page
   logic        req_tlast;    // last_in_trace
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;    // frame_slot, evicted_page, fault_count
   logic [1:0]  rsp_tuser;    // hit, replaced
   logic        rsp_tlast;    // trace_done
   logic        csr_we;
   logic [3:0]  csr_wdata;    // frames_in_use

   int fail_count;
   int outstanding;

   // idle odds in percent for the request and response sides
   int src_idle_pct  = 30;
   int sink_idle_pct = 69;

   clock_page_replacement_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // watches both channels and the csr port, predicts and compares
   clock_page_checker page_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // response side back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // present one request beat, called and returning at a falling edge
   task send_ref(input logic [15:0] pg, input logic lst);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pg;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // frame count changes only once the block has drained
   task program_frames(input logic [3:0] value);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // margin for a sweep still in flight
      repeat (30) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // opening references, last flag in bit 16
   logic [16:0] opening_refs [25] = '{
      // reset frame count of 8: extremes, a hit, fill all frames
      {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'h1234},
      {1'b0, 16'h5555}, {1'b0, 16'hAAAA}, {1'b0, 16'h00FF}, {1'b0, 16'hFF00},
      {1'b0, 16'h8001},
      // full sweep clearing every bit, a hit, a second-chance skip, end of trace
      {1'b0, 16'h7FFE}, {1'b0, 16'hFFFF}, {1'b0, 16'h4242}, {1'b1, 16'h0001},
      // single frame: fill, hit, two evictions
      {1'b0, 16'h0010}, {1'b0, 16'h0010}, {1'b0, 16'h0020}, {1'b1, 16'h0030},
      // frame count of zero behaves as one
      {1'b0, 16'h0040}, {1'b0, 16'h0050}, {1'b1, 16'h0050},
      // count above the frame total, trace left open across the next change
      {1'b0, 16'h0C0C}, {1'b0, 16'h3C3C}, {1'b0, 16'h9999}, {1'b0, 16'h0C0C},
      {1'b0, 16'hE001}
   };

   // one frame count per random phase, extremes included
   logic [3:0] phase_frames [9] = '{4'd3, 4'd8, 4'd1, 4'd6, 4'd15, 4'd2, 4'd0, 4'd5, 4'd8};

   initial begin
      logic [15:0] pool [12];
      int          pool_size;
      int          trace_left;
      logic [15:0] pg;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      pool_size  = 1;
      trace_left = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening, frame count changes between its traces
      for (int i = 0; i < 25; i++) begin
         if (i == 13) program_frames(4'd1);
         if (i == 17) program_frames(4'd0);
         if (i == 20) program_frames(4'd15);
         send_ref(opening_refs[i][15:0], opening_refs[i][16]);
      end

      // random traces; an open trace runs on across each frame count change
      for (int ph = 0; ph < 9; ph++) begin
         program_frames(phase_frames[ph]);
         if (ph == 3) begin
            src_idle_pct  = 69;
            sink_idle_pct = 30;
         end else if (ph == 6) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         for (int n = 0; n < 208; n++) begin
            if (trace_left == 0) begin
               // new trace: small working set so that hits and sweeps are common
               trace_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
               pool_size  = $urandom_range(1, 12);
               for (int k = 0; k < pool_size; k++) begin
                  case ($urandom_range(7))
                     0:       pool[k] = 16'h0000;
                     1:       pool[k] = 16'hFFFF;
                     default: pool[k] = 16'($urandom_range(16'hFFFF));
                  endcase
               end
            end
            if ($urandom_range(9) < 8) pg = pool[$urandom_range(pool_size - 1)];
            else pg = 16'($urandom_range(16'hFFFF));
            trace_left--;
            send_ref(pg, trace_left == 0);
         end
      end

      // drain and settle
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS clock_page_replacement_top");
      end else begin
         $display("FAIL clock_page_replacement_top");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("FAIL clock_page_replacement_top");
      $finish;
   end

endmodule

// ===== clock_page_replacement_top.f =====
design/cpr_pkg.sv
design/cpr_cell.sv
design/cpr_chain.sv
design/clock_page_replacement_top.sv
test/clock_page_checker.sv
test/tb_clock_page_replacement_top.sv
